FILE: src/assert_macros.svh
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rmts_pkg.sv
package rmts_pkg;

   localparam int NumTasks   = 8;
   localparam int QueueDepth = 16;
   localparam int SlotW      = 3;
   localparam int QIdxW      = 4;
   localparam int TimeW      = 32;
   localparam int CountW     = 16;
   localparam int OutW       = 4;
   localparam logic [OutW-1:0] SlotIdle = 4'd8;

   localparam logic ReqLoad = 1'b0;
   localparam logic ReqTick = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DROP,
      ST_REL,
      ST_BEST,
      ST_PREEMPT,
      ST_FIN_CHK,
      ST_MISS_CHK,
      ST_BEST2,
      ST_TAKE2,
      ST_DONE
   } state_type;

   // Request word, fields from highest bit down.
   typedef struct packed {
      logic [CountW-1:0] instance_count;
      logic [CountW-1:0] exec_time;
      logic [CountW-1:0] period;
      logic [SlotW-1:0]  task_slot;
   } req_word_type;

   typedef struct packed {
      logic [7:0]      released_mask;
      logic [7:0]      missed_mask;
      logic            preempted;
      logic [SlotW-1:0] finished_slot;
      logic            finished_valid;
      logic [OutW-1:0] running_slot;
   } rsp_word_type;

   // Compare request to the shared ranking unit.
   typedef struct packed {
      logic [SlotW-1:0] a_slot;
      logic [TimeW-1:0] a_dl;
      logic [CountW-1:0] a_per;
      logic [SlotW-1:0] b_slot;
      logic [TimeW-1:0] b_dl;
      logic [CountW-1:0] b_per;
   } rank_req_type;

endpackage

FILE: src/rmts_rank.sv
// Shared ranking unit: a before b in rate-monotonic order.
module rmts_rank (
   input  rmts_pkg::rank_req_type rank_req,
   output logic                   a_first
);
   import rmts_pkg::*;

   always_comb begin
      if (rank_req.a_per != rank_req.b_per) begin
         a_first = rank_req.a_per < rank_req.b_per;
      end else if (rank_req.a_slot != rank_req.b_slot) begin
         a_first = rank_req.a_slot < rank_req.b_slot;
      end else begin
         a_first = rank_req.a_dl < rank_req.b_dl;
      end
   end
endmodule

FILE: src/rmts_modulo.sv
// Bit-serial remainder tick_time % period, one quotient bit per cycle.
module rmts_modulo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rmts_pkg::TimeW-1:0]    dividend,
   input  logic [rmts_pkg::CountW-1:0]   divisor,
   output logic                          done,
   output logic [rmts_pkg::CountW-1:0]   remainder
);
   import rmts_pkg::*;

   logic [TimeW-1:0]  num_ff, num_in;
   logic [CountW:0]   rem_ff, rem_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [CountW:0]   trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[CountW-1:0], num_ff[TimeW-1]};
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         cnt_in  = 6'(TimeW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[TimeW-2:0], 1'b0};
         rem_in = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done      = busy_ff && (cnt_ff == 6'd1);
   assign remainder = rem_in[CountW-1:0];
endmodule

FILE: src/rate_monotonic_tick_scheduler.sv
// Rate-monotonic tick scheduler, sequencer over one shared ranking compare.
// A tick runs a drop scan of the queue, a release scan of the tasks and a best-job scan,
// then up to two re-dispatch scans, after a finish and after a deadline miss.
// A load waits for the bit-serial modulo unit, unless the period is zero.
// One word in flight: the next word is accepted only after the response word is taken.
// Synchronous active-high reset: idle processor, empty queue, time zero.
module rate_monotonic_tick_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: task_slot[2:0], period[18:3], exec_time[34:19], instance_count[50:35]
   input  logic [55:0] req_tdata,
   // tuser: req_type
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: running_slot[3:0], finished_valid[4], finished_slot[7:5],
   //        preempted[8], missed_mask[16:9], released_mask[24:17]
   output logic [31:0] rsp_tdata
);
   import rmts_pkg::*;

   state_type state_ff, state_in;

   // Task tables (period/exec undefined until loaded).
   logic [CountW-1:0] per_ff   [NumTasks];
   logic [CountW-1:0] exe_ff   [NumTasks];
   logic [CountW-1:0] inst_ff  [NumTasks];
   logic [CountW-1:0] cdown_ff [NumTasks];

   // Ready queue, kept in registers; valid bits reset.
   logic              qv_ff [QueueDepth];
   logic [SlotW-1:0]  qs_ff [QueueDepth];
   logic [TimeW-1:0]  qd_ff [QueueDepth];
   logic [CountW-1:0] qc_ff [QueueDepth];

   logic [TimeW-1:0]  time_ff;
   logic              cv_ff;
   logic [SlotW-1:0]  cs_ff;
   logic [TimeW-1:0]  cd_ff;
   logic [CountW-1:0] cc_ff;

   req_word_type      req_ff;
   logic [QIdxW-1:0]  idx_ff;          // scan counter
   logic              best_v_ff;
   logic [QIdxW-1:0]  best_ff;
   logic [7:0]        miss_ff, rel_ff;
   logic              fin_v_ff, pre_ff;
   logic [SlotW-1:0]  fin_s_ff;
   logic              miss_phase_ff;   // re-dispatch follows a deadline miss

   logic              rsp_v_ff;
   rsp_word_type      rsp_ff;

   // Shared ranking compare.
   rank_req_type      rank_req;
   logic              a_first;
   logic [QIdxW-1:0]  qi;
   logic [SlotW-1:0]  ti;
   logic [CountW-1:0] cur_per, cur_exe;
   logic              cur_unfin;

   logic              mod_start, mod_done;
   logic [CountW-1:0] mod_rem;

   assign qi = idx_ff;
   assign ti = idx_ff[SlotW-1:0];
   assign cur_per   = per_ff[cs_ff];
   assign cur_exe   = exe_ff[cs_ff];
   assign cur_unfin = cc_ff < cur_exe;

   assign rank_req.a_slot = qs_ff[qi];
   assign rank_req.a_dl   = qd_ff[qi];
   assign rank_req.a_per  = per_ff[qs_ff[qi]];
   assign rank_req.b_slot = qs_ff[best_ff];
   assign rank_req.b_dl   = qd_ff[best_ff];
   assign rank_req.b_per  = per_ff[qs_ff[best_ff]];

   rmts_rank u_rank (.rank_req(rank_req), .a_first(a_first));

   rmts_modulo u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (time_ff),
      .divisor  (req_ff.period),
      .done     (mod_done),
      .remainder(mod_rem)
   );

   // First free queue entry (priority encoder over valid bits).
   logic             free_v;
   logic [QIdxW-1:0] free_i;
   always_comb begin
      free_v = 1'b0;
      free_i = '0;
      for (int i = QueueDepth - 1; i >= 0; i--) begin
         if (!qv_ff[i]) begin
            free_v = 1'b1;
            free_i = QIdxW'(i);
         end
      end
   end

   // Preempted job lands in the first free entry once the winner's is released.
   logic [QIdxW-1:0] swap_i;
   assign swap_i = (free_v && free_i < best_ff) ? free_i : best_ff;

   assign req_tready = (state_ff == ST_IDLE) && !rsp_v_ff;
   assign mod_start  = (state_ff == ST_IDLE) && req_tvalid && req_tready &&
                       (req_tuser == ReqLoad) && (req_tdata[15:3] != '0 || req_tdata[18:16] != '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_tvalid && req_tready) begin
            if (req_tuser == ReqTick) state_in = ST_DROP;
            else if (req_tdata[18:3] != '0) state_in = ST_LOAD;
            else state_in = ST_DONE;
         end
         ST_LOAD:     if (mod_done) state_in = ST_DONE;
         ST_DROP:     if (qi == QIdxW'(QueueDepth - 1)) state_in = ST_REL;
         ST_REL:      if (ti == SlotW'(NumTasks - 1)) state_in = ST_BEST;
         ST_BEST:     if (qi == QIdxW'(QueueDepth - 1)) state_in = ST_PREEMPT;
         ST_PREEMPT:  state_in = ST_FIN_CHK;
         ST_FIN_CHK:  state_in = (cv_ff && !cur_unfin) ? ST_BEST2 : ST_MISS_CHK;
         ST_MISS_CHK: state_in = (cv_ff && cd_ff <= time_ff && cur_unfin) ? ST_BEST2 : ST_DONE;
         ST_BEST2:    if (qi == QIdxW'(QueueDepth - 1)) state_in = ST_TAKE2;
         ST_TAKE2:    state_in = miss_phase_ff ? ST_DONE : ST_MISS_CHK;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_v_ff <= 1'b0;
         time_ff  <= '0;
         cv_ff    <= 1'b0;
         cs_ff    <= '0;
         cd_ff    <= '0;
         cc_ff    <= '0;
         for (int i = 0; i < QueueDepth; i++) qv_ff[i] <= 1'b0;
         for (int i = 0; i < NumTasks; i++) begin
            inst_ff[i]  <= '0;
            cdown_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_v_ff && rsp_tready) rsp_v_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               req_ff    <= req_word_type'(req_tdata[50:0]);
               idx_ff    <= '0;
               best_v_ff <= 1'b0;
               miss_ff   <= '0;
               rel_ff    <= '0;
               fin_v_ff  <= 1'b0;
               fin_s_ff  <= '0;
               pre_ff    <= 1'b0;
               if (req_tuser == ReqLoad) begin
                  per_ff[req_tdata[2:0]]   <= req_tdata[18:3];
                  exe_ff[req_tdata[2:0]]   <= req_tdata[34:19];
                  inst_ff[req_tdata[2:0]]  <= req_tdata[50:35];
                  cdown_ff[req_tdata[2:0]] <= '0;
               end
            end
            ST_LOAD: if (mod_done) begin
               cdown_ff[req_ff.task_slot] <= (mod_rem == '0) ? '0 :
                                             req_ff.period - mod_rem;
            end
            ST_DROP: begin
               if (qv_ff[qi] && qd_ff[qi] <= time_ff) begin
                  qv_ff[qi] <= 1'b0;
                  miss_ff[qs_ff[qi]] <= 1'b1;
               end
               if (qi == QIdxW'(QueueDepth - 1)) begin
                  idx_ff <= '0;
                  if (cv_ff && cc_ff != '1) cc_ff <= cc_ff + 1'b1;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_REL: begin
               if (cdown_ff[ti] == '0) begin
                  if (per_ff[ti] != '0 && inst_ff[ti] != '0) begin
                     inst_ff[ti] <= inst_ff[ti] - 1'b1;
                     if (free_v) begin
                        qv_ff[free_i] <= 1'b1;
                        qs_ff[free_i] <= ti;
                        qd_ff[free_i] <= time_ff + TimeW'(per_ff[ti]);
                        qc_ff[free_i] <= '0;
                        rel_ff[ti]    <= 1'b1;
                     end else begin
                        miss_ff[ti] <= 1'b1;
                     end
                  end
                  cdown_ff[ti] <= (per_ff[ti] != '0) ? per_ff[ti] - 1'b1 : '0;
               end else begin
                  cdown_ff[ti] <= cdown_ff[ti] - 1'b1;
               end
               idx_ff <= (ti == SlotW'(NumTasks - 1)) ? '0 : idx_ff + 1'b1;
            end
            ST_BEST, ST_BEST2: begin
               if (qv_ff[qi] && (!best_v_ff || a_first)) begin
                  best_v_ff <= 1'b1;
                  best_ff   <= qi;
               end
               idx_ff <= (qi == QIdxW'(QueueDepth - 1)) ? '0 : idx_ff + 1'b1;
            end
            ST_PREEMPT: begin
               if (best_v_ff) begin
                  if (!cv_ff) begin
                     cv_ff <= 1'b1;
                     cs_ff <= qs_ff[best_ff];
                     cd_ff <= qd_ff[best_ff];
                     cc_ff <= qc_ff[best_ff];
                     qv_ff[best_ff] <= 1'b0;
                  end else if (cur_per > rank_req.b_per && cur_unfin) begin
                     cs_ff <= qs_ff[best_ff];
                     cd_ff <= qd_ff[best_ff];
                     cc_ff <= qc_ff[best_ff];
                     // old job goes back to the first free entry
                     if (swap_i != best_ff) begin
                        qv_ff[best_ff] <= 1'b0;
                        qv_ff[swap_i]  <= 1'b1;
                     end
                     qs_ff[swap_i] <= cs_ff;
                     qd_ff[swap_i] <= cd_ff;
                     qc_ff[swap_i] <= cc_ff;
                     pre_ff <= 1'b1;
                  end
               end
            end
            ST_FIN_CHK: begin
               best_v_ff     <= 1'b0;
               miss_phase_ff <= 1'b0;
               if (cv_ff && !cur_unfin) begin
                  fin_v_ff <= 1'b1;
                  fin_s_ff <= cs_ff;
               end
            end
            // Also covers a job just dispatched after a finish.
            ST_MISS_CHK: begin
               best_v_ff     <= 1'b0;
               miss_phase_ff <= 1'b1;
               if (cv_ff && cd_ff <= time_ff && cur_unfin) begin
                  miss_ff[cs_ff] <= 1'b1;
               end else begin
                  time_ff <= time_ff + 1'b1;
               end
            end
            ST_TAKE2: begin
               if (best_v_ff) begin
                  cv_ff <= 1'b1;
                  cs_ff <= qs_ff[best_ff];
                  cd_ff <= qd_ff[best_ff];
                  cc_ff <= qc_ff[best_ff];
                  qv_ff[best_ff] <= 1'b0;
               end else begin
                  cv_ff <= 1'b0;
               end
               if (miss_phase_ff) time_ff <= time_ff + 1'b1;
            end
            ST_DONE: begin
               rsp_v_ff <= 1'b1;
               rsp_ff.running_slot   <= cv_ff ? {1'b0, cs_ff} : SlotIdle;
               rsp_ff.finished_valid <= fin_v_ff;
               rsp_ff.finished_slot  <= fin_s_ff;
               rsp_ff.preempted      <= pre_ff;
               rsp_ff.missed_mask    <= miss_ff;
               rsp_ff.released_mask  <= rel_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {7'd0, rsp_ff};
endmodule

FILE: src/rmts_checker.sv
`include "assert_macros.svh"
module rmts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")
   `ASSERT_IMPL(a_no_ready_with_rsp, clock, reset, rsp_tvalid, !req_tready, "accepted word while result pending")
   `ASSERT_IMPL(a_slot_range, clock, reset, rsp_tvalid, rsp_tdata[3:0] <= 4'd8, "running slot out of range")
   `ASSERT_IMPL(a_fin_zero, clock, reset, rsp_tvalid && !rsp_tdata[4], rsp_tdata[7:5] == 3'd0, "finished slot without finish")
endmodule

bind rate_monotonic_tick_scheduler rmts_checker u_rmts_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
